@@ sv/tshe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tshe_pkg;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 32;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int ONE_VAL   = 1 << FRAC_BITS;
  localparam int NORM_PAD  = ((1 << FRAC_BITS) + 50) / 100;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MIN   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIFF  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NORM  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_STAMP_RADIUS = 2'd2;

  localparam logic [8:0] NO_SPOT = 9'h1FF;
endpackage
`default_nettype wire

@@ sv/toroidal_stamp_heightmap_engine_top.sv @@
// Channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata: cmd, coord_x, coord_y, stamp_index, value
// m       | out | m_tvalid/m_tready  | m_tdata: read_value, status
// cfg     | in  | psel/penable/pready| paddr, pwrite, pwdata, prdata
// One word at a time. Fill writes all MAX_WIDTH*MAX_HEIGHT map cells, one map write each.
// A stamp does one read-modify-write of the map memory per cell of its (2r+1)^2 cells.
// Normalize scans the w*h cells for min/max, then runs each through the bit-serial divider.
// rst is synchronous; the memories are not cleared. A stalled m side holds the
// finished word and the next word is taken meanwhile; its result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
module toroidal_stamp_heightmap_engine_top #(
  parameter int MAX_WIDTH  = tshe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tshe_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = tshe_pkg::MAX_RADIUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd[2:0], coord_x[10:3], coord_y[18:11], stamp_index[31:19], value[48:32]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_value[16:0], status[18:17]
  output logic [23:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int VW        = tshe_pkg::VAL_W;
  localparam int FB        = tshe_pkg::FRAC_BITS;
  localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int WCW       = $clog2(MAX_WIDTH + 1);
  localparam int HCW       = $clog2(MAX_HEIGHT + 1);
  localparam int RCW       = $clog2(MAX_RADIUS + 1);
  localparam int SDW       = RCW + 1;
  localparam int SIDE_MAX  = 2 * MAX_RADIUS + 1;
  localparam int STAMP_CELLS = SIDE_MAX * SIDE_MAX;
  localparam int STW       = $clog2(STAMP_CELLS);
  localparam int SW        = $clog2(SIDE_MAX);
  localparam int CW        = 12;
  localparam int RW        = VW + 1;
  localparam int DCW       = $clog2(FB + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_PRESS = 4'd2;
  localparam logic [3:0] S_NSCAN = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NLD   = 4'd5;
  localparam logic [3:0] S_NDIV  = 4'd6;
  localparam logic [3:0] S_RDA   = 4'd7;
  localparam logic [3:0] S_RDB   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state;

  // configuration
  logic [WCW-1:0] map_width;
  logic [HCW-1:0] map_height;
  logic [RCW-1:0] stamp_radius;
  logic           cfg_wr;
  logic [8:0]     wd9;
  logic [5:0]     wd6;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wd9    = pwdata[8:0];
  assign wd6    = pwdata[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= WCW'(MAX_WIDTH);
      map_height   <= HCW'(MAX_HEIGHT);
      stamp_radius <= RCW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tshe_pkg::REG_MAP_WIDTH: begin
          if (wd9 == 9'd0) map_width <= WCW'(1);
          else if (32'(wd9) > MAX_WIDTH) map_width <= WCW'(MAX_WIDTH);
          else map_width <= WCW'(wd9);
        end
        tshe_pkg::REG_MAP_HEIGHT: begin
          if (wd9 == 9'd0) map_height <= HCW'(1);
          else if (32'(wd9) > MAX_HEIGHT) map_height <= HCW'(MAX_HEIGHT);
          else map_height <= HCW'(wd9);
        end
        tshe_pkg::REG_STAMP_RADIUS: begin
          if (wd6 == 6'd0) stamp_radius <= RCW'(1);
          else if (32'(wd6) > MAX_RADIUS) stamp_radius <= RCW'(MAX_RADIUS);
          else stamp_radius <= RCW'(wd6);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tshe_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width);
      tshe_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_height);
      tshe_pkg::REG_STAMP_RADIUS: prdata = 32'(stamp_radius);
      default:                    prdata = 32'd0;
    endcase
  end

  // input word fields
  logic [2:0]    in_cmd;
  logic [7:0]    in_x, in_y;
  logic [12:0]   in_sidx;
  logic [16:0]   in_val;
  logic [VW-1:0] in_sat;
  logic          s_acc;

  assign in_cmd  = s_tdata[2:0];
  assign in_x    = s_tdata[10:3];
  assign in_y    = s_tdata[18:11];
  assign in_sidx = s_tdata[31:19];
  assign in_val  = s_tdata[48:32];
  assign in_sat  = (32'(in_val) > tshe_pkg::ONE_VAL) ? VW'(tshe_pkg::ONE_VAL) : VW'(in_val);
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  logic [SDW-1:0]   side;
  logic [2*SDW-1:0] side_sq;
  logic             coord_bad, size_bad;
  logic [CW-1:0]    px0_w, py0_w;

  assign side      = {stamp_radius, 1'b1};
  assign side_sq   = (2*SDW)'(side) * (2*SDW)'(side);
  assign coord_bad = (CW'(in_x) >= CW'(map_width)) || (CW'(in_y) >= CW'(map_height));
  assign size_bad  = (CW'(side) > CW'(map_width)) || (CW'(side) > CW'(map_height));

  // wrapped start corner: center minus radius, one correction
  always_comb begin
    px0_w = CW'(in_x) + CW'(map_width) - CW'(stamp_radius);
    if (px0_w >= CW'(map_width)) px0_w = px0_w - CW'(map_width);
    py0_w = CW'(in_y) + CW'(map_height) - CW'(stamp_radius);
    if (py0_w >= CW'(map_height)) py0_w = py0_w - CW'(map_height);
  end

  // item registers
  logic [2:0]     cmd_r;
  logic [VW-1:0]  val_r;
  logic [1:0]     st_r;
  logic [VW-1:0]  rd_r;
  logic [7:0]     cx_r, cy_r;
  logic [8:0]     last_min_x, last_min_y, last_diff_x, last_diff_y;

  // walk registers
  logic [XW-1:0]  px, px0_r;
  logic [YW-1:0]  py;
  logic [SW-1:0]  ci, cj;
  logic [STW-1:0] scnt;
  logic [AW-1:0]  fcnt;
  logic           iss_done, p1_vld;
  logic [AW-1:0]  p1_addr;
  logic [VW-1:0]  lo, hi;
  logic [RW-1:0]  range_r;
  logic [RW:0]    rem;
  logic [FB-1:0]  quo;
  logic [DCW-1:0] dcnt;

  logic           x_end, y_end, i_end, j_end;
  logic [XW-1:0]  px_inc;
  logic [YW-1:0]  py_inc;
  logic [AW-1:0]  cur_addr;

  assign x_end    = (px == XW'(map_width - WCW'(1)));
  assign y_end    = (py == YW'(map_height - HCW'(1)));
  assign i_end    = (ci == SW'(side - SDW'(1)));
  assign j_end    = (cj == SW'(side - SDW'(1)));
  assign px_inc   = x_end ? '0 : px + XW'(1);
  assign py_inc   = y_end ? '0 : py + YW'(1);
  assign cur_addr = AW'(px) + AW'(py) * AW'(MAX_WIDTH);

  // memories
  logic [VW-1:0] hmem [MAP_CELLS];
  logic [VW-1:0] smem [STAMP_CELLS];
  logic [VW-1:0] h_q, s_q;
  logic          h_we;
  logic [AW-1:0] h_waddr;
  logic [VW-1:0] h_wdata;
  logic          s_we;

  assign s_we = s_acc && (in_cmd == tshe_pkg::CMD_LOAD) && ((2*SDW)'(in_sidx) < side_sq);

  always_ff @(posedge clk) begin
    h_q <= hmem[cur_addr];
    if (h_we) hmem[h_waddr] <= h_wdata;
  end

  always_ff @(posedge clk) begin
    s_q <= smem[scnt];
    if (s_we) smem[STW'(in_sidx)] <= in_sat;
  end

  logic [VW-1:0] inv, press_new;
  logic [RW:0]   rem_sh;

  assign inv    = VW'(tshe_pkg::ONE_VAL) - s_q;
  assign rem_sh = {rem[RW-1:0], 1'b0};

  always_comb begin
    if (cmd_r == tshe_pkg::CMD_DIFF) press_new = (inv > h_q) ? inv - h_q : h_q - inv;
    else press_new = (h_q > s_q) ? s_q : h_q;
  end

  // decode of the accepted word
  logic          same_spot;
  logic [3:0]    state_next;
  logic [1:0]    st_next;
  logic [XW-1:0] px_next;
  logic [YW-1:0] py_next;

  assign same_spot = (in_cmd == tshe_pkg::CMD_MIN && {1'b0, in_x} == last_min_x &&
                      {1'b0, in_y} == last_min_y) ||
                     (in_cmd == tshe_pkg::CMD_DIFF && {1'b0, in_x} == last_diff_x &&
                      {1'b0, in_y} == last_diff_y);

  always_comb begin
    state_next = S_FIN;
    st_next    = tshe_pkg::ST_DONE;
    px_next    = XW'(in_x);
    py_next    = YW'(in_y);
    unique case (in_cmd) inside
      tshe_pkg::CMD_FILL: state_next = S_FILL;
      tshe_pkg::CMD_LOAD: begin
        if (!s_we) st_next = tshe_pkg::ST_RANGE;
      end
      tshe_pkg::CMD_MIN, tshe_pkg::CMD_DIFF: begin
        px_next = XW'(px0_w);
        py_next = YW'(py0_w);
        if (coord_bad || size_bad) st_next = tshe_pkg::ST_RANGE;
        else if (same_spot) st_next = tshe_pkg::ST_SKIP;
        else state_next = S_PRESS;
      end
      tshe_pkg::CMD_NORM: begin
        px_next    = '0;
        py_next    = '0;
        state_next = S_NSCAN;
      end
      tshe_pkg::CMD_READ: begin
        if (coord_bad) st_next = tshe_pkg::ST_RANGE;
        else state_next = S_RDA;
      end
      default: ;
    endcase
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = p1_addr;
    h_wdata = press_new;
    unique case (state)
      S_FILL: begin
        h_we    = 1'b1;
        h_waddr = fcnt;
        h_wdata = val_r;
      end
      S_PRESS: h_we = p1_vld;
      S_NDIV: begin
        h_we    = (dcnt == DCW'(FB));
        h_wdata = VW'(quo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      last_min_x  <= tshe_pkg::NO_SPOT;
      last_min_y  <= tshe_pkg::NO_SPOT;
      last_diff_x <= tshe_pkg::NO_SPOT;
      last_diff_y <= tshe_pkg::NO_SPOT;
      p1_vld      <= 1'b0;
      iss_done    <= 1'b0;
    end else begin
      // S_FIN drives valid itself
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            cmd_r    <= in_cmd;
            val_r    <= in_sat;
            cx_r     <= in_x;
            cy_r     <= in_y;
            st_r     <= st_next;
            rd_r     <= '0;
            fcnt     <= '0;
            ci       <= '0;
            cj       <= '0;
            scnt     <= '0;
            iss_done <= 1'b0;
            p1_vld   <= 1'b0;
            px       <= px_next;
            py       <= py_next;
            px0_r    <= XW'(px0_w);
            lo       <= '1;
            hi       <= '0;
            state    <= state_next;
            if (s_we) begin
              last_min_x  <= tshe_pkg::NO_SPOT;
              last_min_y  <= tshe_pkg::NO_SPOT;
              last_diff_x <= tshe_pkg::NO_SPOT;
              last_diff_y <= tshe_pkg::NO_SPOT;
            end
          end
        end
        S_FILL: begin
          fcnt <= fcnt + AW'(1);
          if (32'(fcnt) == MAP_CELLS - 1) state <= S_FIN;
        end
        S_PRESS: begin
          p1_vld <= !iss_done;
          if (!iss_done) begin
            p1_addr <= cur_addr;
            scnt    <= scnt + STW'(1);
            if (i_end) begin
              ci <= '0;
              px <= px0_r;
              py <= py_inc;
              if (j_end) iss_done <= 1'b1;
              else cj <= cj + SW'(1);
            end else begin
              ci <= ci + SW'(1);
              px <= px_inc;
            end
          end else if (!p1_vld) begin
            if (cmd_r == tshe_pkg::CMD_DIFF) begin
              last_diff_x <= {1'b0, cx_r};
              last_diff_y <= {1'b0, cy_r};
            end else begin
              last_min_x <= {1'b0, cx_r};
              last_min_y <= {1'b0, cy_r};
            end
            state <= S_FIN;
          end
        end
        S_NSCAN: begin
          p1_vld <= !iss_done;
          if (!iss_done) begin
            px <= px_inc;
            if (x_end) begin
              py <= py_inc;
              if (y_end) iss_done <= 1'b1;
            end
          end
          if (p1_vld) begin
            if (h_q < lo) lo <= h_q;
            if (h_q > hi) hi <= h_q;
          end
          if (iss_done && !p1_vld) begin
            range_r <= RW'(hi - lo) + RW'(2 * tshe_pkg::NORM_PAD);
            state   <= S_NRD;
          end
        end
        S_NRD: begin
          p1_addr <= cur_addr;
          state   <= S_NLD;
        end
        S_NLD: begin
          rem   <= (RW+1)'(h_q - lo) + (RW+1)'(tshe_pkg::NORM_PAD);
          quo   <= '0;
          dcnt  <= '0;
          state <= S_NDIV;
        end
        S_NDIV: begin
          if (dcnt == DCW'(FB)) begin
            // word written this cycle; advance to the next cell
            px <= px_inc;
            if (x_end) py <= py_inc;
            state <= (x_end && y_end) ? S_FIN : S_NRD;
          end else begin
            dcnt <= dcnt + DCW'(1);
            if (rem_sh >= (RW+1)'(range_r)) begin
              rem <= rem_sh - (RW+1)'(range_r);
              quo <= {quo[FB-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[FB-2:0], 1'b0};
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          rd_r  <= h_q;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, st_r, 17'(rd_r)};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !h_we) else $error("map write while idle");
  a_pipe_state: assert property (@(posedge clk) disable iff (rst)
    p1_vld |-> (state == S_PRESS || state == S_NSCAN)) else $error("stray pipe valid");
  a_skip_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && st_r == tshe_pkg::ST_SKIP) |->
      (cmd_r == tshe_pkg::CMD_MIN || cmd_r == tshe_pkg::CMD_DIFF))
    else $error("skip on non-stamp command");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_NDIV) |-> (rem < (RW+1)'(range_r))) else $error("divider remainder overflow");
`endif
endmodule
`default_nettype wire
